/* hw/rtl/frx_pkg.sv */
// Shared types and constants for the XOR-checked frame receiver.
package frx_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int ADDR_BYTES   = 4;
  localparam int WIN_IDX_W    = $clog2(HEADER_BYTES);
  localparam int COUNT_W      = 17;
  localparam int LEN_W        = 16;
  localparam int ADDR_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int STATUS_W     = 3;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd4096;

  // Output tdata layout, lowest bit first.
  localparam int PBYTE_LSB  = 0;
  localparam int PINDEX_LSB = PBYTE_LSB + BYTE_W;
  localparam int ADDR_LSB   = PINDEX_LSB + LEN_W;
  localparam int LEN_LSB    = ADDR_LSB + ADDR_W;
  localparam int ACK_BIT    = LEN_LSB + LEN_W;
  localparam int OUT_DATA_W = ((ACK_BIT + 1 + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    ST_HEADER  = 3'd0,
    ST_PAYLOAD = 3'd1,
    ST_GOOD    = 3'd2,
    ST_BADSUM  = 3'd3,
    ST_SHIFT   = 3'd4
  } status_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] payload_byte;
    logic [LEN_W-1:0]  payload_index;
    logic [ADDR_W-1:0] frame_addr;
    logic [LEN_W-1:0]  frame_len;
    logic              send_ack;
  } result_t;

endpackage

/* hw/rtl/frx_core.sv */
// Frame parser state and the per-word update: header window, counters, checksum.
module frx_core
  import frx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output result_t           res
);

  logic [BYTE_W-1:0]  win      [HEADER_BYTES];
  logic [BYTE_W-1:0]  win_new  [HEADER_BYTES];
  logic [BYTE_W-1:0]  win_next [HEADER_BYTES];
  logic [COUNT_W-1:0] byte_count;
  logic [COUNT_W-1:0] byte_count_next;
  logic [LEN_W-1:0]   latched_len;
  logic [ADDR_W-1:0]  latched_addr;
  logic [BYTE_W-1:0]  payload_xor;
  logic [BYTE_W-1:0]  payload_xor_next;
  logic [LEN_W-1:0]   max_len;

  logic               hdr_phase;
  logic               pay_phase;
  logic               hdr_full;
  logic               reject;
  logic [ADDR_W-1:0]  dec_addr;
  logic [LEN_W-1:0]   dec_len;
  logic [BYTE_W-1:0]  win_xor;
  logic [COUNT_W-1:0] frame_end;
  logic [COUNT_W-1:0] pay_offset;

  assign hdr_phase  = byte_count < COUNT_W'(HEADER_BYTES);
  assign frame_end  = COUNT_W'(HEADER_BYTES) + {1'b0, latched_len};
  assign pay_phase  = !hdr_phase && (byte_count < frame_end);
  assign hdr_full   = hdr_phase && (byte_count == COUNT_W'(HEADER_BYTES - 1));
  assign pay_offset = byte_count - COUNT_W'(HEADER_BYTES);

  // Window with the incoming byte placed at the current fill position.
  always_comb begin
    for (int i = 0; i < HEADER_BYTES; i++) begin
      win_new[i] = (byte_count[WIN_IDX_W-1:0] == WIN_IDX_W'(i)) ? rx_byte : win[i];
    end
  end

  always_comb begin
    dec_addr = '0;
    for (int i = 0; i < ADDR_BYTES; i++) begin
      dec_addr = {dec_addr[ADDR_W-BYTE_W-1:0], win_new[i]};
    end
    dec_len = {win_new[ADDR_BYTES], win_new[ADDR_BYTES+1]};
    win_xor = '0;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      win_xor = win_xor ^ win_new[i];
    end
  end

  assign reject = (dec_len == '0) || (dec_len > max_len);

  always_comb begin
    win_next         = win;
    byte_count_next  = byte_count;
    payload_xor_next = payload_xor;
    res.status        = ST_HEADER;
    res.payload_byte  = '0;
    res.payload_index = '0;
    res.frame_addr    = latched_addr;
    res.frame_len     = latched_len;
    res.send_ack      = 1'b0;
    if (hdr_phase) begin
      win_next        = win_new;
      byte_count_next = byte_count + COUNT_W'(1);
      if (hdr_full) begin
        res.frame_addr = dec_addr;
        res.frame_len  = dec_len;
        if (reject) begin
          // Drop the oldest byte and keep looking for a header.
          for (int i = 0; i < HEADER_BYTES - 1; i++) begin
            win_next[i] = win_new[i+1];
          end
          win_next[HEADER_BYTES-1] = '0;
          byte_count_next          = COUNT_W'(HEADER_BYTES - 1);
          res.status               = ST_SHIFT;
        end else begin
          payload_xor_next = win_xor;
        end
      end
    end else if (pay_phase) begin
      res.status        = ST_PAYLOAD;
      res.payload_byte  = rx_byte;
      res.payload_index = pay_offset[LEN_W-1:0];
      payload_xor_next  = payload_xor ^ rx_byte;
      byte_count_next   = byte_count + COUNT_W'(1);
    end else begin
      if (payload_xor == rx_byte) begin
        res.status   = ST_GOOD;
        res.send_ack = 1'b1;
      end else begin
        res.status = ST_BADSUM;
      end
      byte_count_next  = '0;
      payload_xor_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        win[i] <= '0;
      end
      byte_count   <= '0;
      latched_len  <= '0;
      latched_addr <= '0;
      payload_xor  <= '0;
      max_len      <= MAX_LEN_RESET;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (step) begin
        win         <= win_next;
        byte_count  <= byte_count_next;
        payload_xor <= payload_xor_next;
        if (hdr_full) begin
          latched_addr <= dec_addr;
          latched_len  <= dec_len;
        end
      end
    end
  end

endmodule

/* hw/rtl/xor_frame_receiver_resync.sv */
// Top level of the length-prefixed frame receiver with XOR checksum and header resync.
//
// The block takes one received serial byte per word on the slave stream and returns exactly
// one result word per byte on the master stream. A frame is a 4-byte big-endian address, a
// 2-byte big-endian payload length, that many payload bytes and a checksum byte equal to the
// XOR of all earlier frame bytes. While the header is collected each byte reports "header";
// once six header bytes are in, a length of zero or above max_payload_len (cfg_wdata, reset
// 4096) makes the receiver drop the oldest byte and slide on by one ("resync shift"). Payload
// bytes come out with their offset in the payload, and the checksum byte ends the frame with
// "frame good" plus send_ack (the caller then transmits the acknowledge byte 0x06) or with
// "checksum error". The decoded address and length of the last full header window are shown
// on every word. Throughput is one byte per clock cycle, sustained under any pattern of
// stalls that does not hold back the master side; an accepted byte is held in the input
// register, and the single parsing step then loads its result into the result register,
// which a stall on the master side can delay. The configuration register must only be
// written while no word is in flight.
module xor_frame_receiver_resync
  import frx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration: max_payload_len.
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_wdata,
  // Slave stream. tdata: rx_byte [7:0].
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [BYTE_W-1:0]     s_axis_tdata,
  // Master stream. tdata from bit 0 up: payload_byte [7:0], payload_index [23:8],
  // frame_addr [55:24], frame_len [71:56], send_ack [72], zero fill [79:73].
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: status [2:0].
  output logic [STATUS_W-1:0]   m_axis_tuser
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_valid;
  result_t           out_res;
  result_t           core_res;
  logic              advance;

  // The parser advances when a byte is held and the result register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  frx_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (advance),
    .rx_byte   (in_byte),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {
    (OUT_DATA_W - ACK_BIT - 1)'(0),
    out_res.send_ack,
    out_res.frame_len,
    out_res.frame_addr,
    out_res.payload_index,
    out_res.payload_byte
  };

endmodule

/* hw/rtl/frx_checker.sv */
// Port-level checker for the frame receiver, bound to the top level.
module frx_checker
  import frx_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic [STATUS_W-1:0]   m_axis_tuser
);

  // A stalled result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // The acknowledge request goes only with a good frame.
  a_ack: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[ACK_BIT] |-> m_axis_tuser == ST_GOOD)
    else $error("send_ack without frame good");

  // Payload fields are zero unless a payload byte is reported.
  a_pay_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != ST_PAYLOAD |->
      m_axis_tdata[PINDEX_LSB+LEN_W-1:PBYTE_LSB] == '0)
    else $error("payload fields set outside payload");

  // A payload offset always lies inside the accepted nonzero length.
  a_pay_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_PAYLOAD |->
      m_axis_tdata[PINDEX_LSB+LEN_W-1:PINDEX_LSB] < m_axis_tdata[LEN_LSB+LEN_W-1:LEN_LSB])
    else $error("payload offset beyond frame length");

endmodule

bind xor_frame_receiver_resync frx_checker u_frx_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
